// ===== rtl/core/bpse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP pixel stream extractor package
// Shared types, codes and header layout constants for the extractor.
// ----------------------------------------------------------------------------
package bpse_pkg;

  localparam int unsigned MAX_DIMENSION_DEFAULT = 8192;
  localparam int unsigned RESULT_FIFO_DEPTH     = 4;

  localparam logic [15:0] BMP_SIGNATURE   = 16'd16973;
  localparam logic [15:0] DEPTH_24        = 16'd24;
  localparam logic [15:0] DEPTH_32        = 16'd32;

  localparam logic [5:0]  POS_SIGNATURE_HI = 6'd1;
  localparam logic [5:0]  POS_OFFSET_LO    = 6'd10;
  localparam logic [5:0]  POS_WIDTH_LO     = 6'd18;
  localparam logic [5:0]  POS_HEIGHT_LO    = 6'd22;
  localparam logic [5:0]  POS_DEPTH_LO     = 6'd28;
  localparam logic [5:0]  POS_COMP_LO      = 6'd30;
  localparam logic [5:0]  POS_PALETTE_LO   = 6'd46;
  localparam logic [5:0]  HEADER_LAST      = 6'd53;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_PIXEL,
    ST_BAD_SIGNATURE,
    ST_BAD_FORMAT,
    ST_BAD_GEOMETRY
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } byte_item_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [12:0] pixel_column;
    logic [12:0] pixel_row;
    logic        last_pixel;
    status_t     status;
    logic [13:0] image_width;
    logic [13:0] image_height;
    logic [2:0]  bytes_per_pixel;
  } result_item_t;

endpackage

// ===== rtl/core/bpse_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP extractor front end
// Tracks the byte position, captures the header, classifies each byte as
// header, skip, padding or pixel data and builds one result item per pixel
// or per header that fails its checks.
// ----------------------------------------------------------------------------
module bpse_front
  import bpse_pkg::*;
#(
  parameter int unsigned MAX_DIMENSION = MAX_DIMENSION_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         take,
  input  byte_item_t   byte_item,
  output logic         push,
  output result_item_t result
);

  localparam int unsigned CNT_W = $clog2(MAX_DIMENSION + 1);

  logic [31:0]      byte_position;
  logic [15:0]      signature_word;
  logic [31:0]      captured_width;
  logic [31:0]      captured_height;
  logic [15:0]      bit_depth;
  logic             format_bad;
  logic [31:0]      pixel_start;
  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;
  logic [1:0]       byte_in_pixel;
  logic [23:0]      pixel_hold;
  logic [1:0]       padding_left;
  phase_t           phase;

  logic [31:0]      pos_cur, pos_next;
  logic [15:0]      sig_cur, sig_next;
  logic [31:0]      width_cur, width_next;
  logic [31:0]      height_cur, height_next;
  logic [15:0]      depth_cur, depth_next;
  logic             fmt_cur, fmt_next;
  logic [31:0]      start_cur, start_next;
  logic [CNT_W-1:0] col_cur, col_next, col_inc;
  logic [CNT_W-1:0] row_cur, row_next, row_inc;
  logic [1:0]       bip_cur, bip_next;
  logic [23:0]      hold_cur, hold_next;
  logic [1:0]       pad_cur, pad_next;
  phase_t           phase_cur, phase_next;

  logic [7:0]       b;
  logic [5:0]       pos6;
  logic [1:0]       lane;
  logic             hdr_check;
  status_t          hdr_status;
  logic             start_pixels;
  logic             skip_done;
  logic             in_pad;
  logic             bpp3;
  logic             pix_end;
  logic             row_end;
  logic             last;
  logic             pixel_fire;
  logic [13:0]      width_sat;
  logic [13:0]      height_sat;
  logic [2:0]       bpp_out;

  always_comb begin
    b          = byte_item.data_byte;
    if (byte_item.start_of_file) begin
      pos_cur    = '0;
      sig_cur    = '0;
      width_cur  = '0;
      height_cur = '0;
      depth_cur  = '0;
      fmt_cur    = 1'b0;
      start_cur  = '0;
      col_cur    = '0;
      row_cur    = '0;
      bip_cur    = '0;
      hold_cur   = '0;
      pad_cur    = '0;
      phase_cur  = PH_HEADER;
    end else begin
      pos_cur    = byte_position;
      sig_cur    = signature_word;
      width_cur  = captured_width;
      height_cur = captured_height;
      depth_cur  = bit_depth;
      fmt_cur    = format_bad;
      start_cur  = pixel_start;
      col_cur    = column_count;
      row_cur    = row_count;
      bip_cur    = byte_in_pixel;
      hold_cur   = pixel_hold;
      pad_cur    = padding_left;
      phase_cur  = phase;
    end
  end

  always_comb begin
    pos6      = pos_cur[5:0];
    hdr_check = (phase_cur == PH_HEADER) && (pos6 == HEADER_LAST);
    if (sig_cur != BMP_SIGNATURE) begin
      hdr_status = ST_BAD_SIGNATURE;
    end else if (fmt_cur) begin
      hdr_status = ST_BAD_FORMAT;
    end else if ((depth_cur != DEPTH_24) && (depth_cur != DEPTH_32)) begin
      hdr_status = ST_BAD_GEOMETRY;
    end else if ((width_cur == '0) || (width_cur > 32'(MAX_DIMENSION)) ||
                 (height_cur == '0) || (height_cur > 32'(MAX_DIMENSION))) begin
      hdr_status = ST_BAD_GEOMETRY;
    end else begin
      hdr_status = ST_PIXEL;
    end
    start_pixels = start_cur <= (32'(HEADER_LAST) + 32'd1);
    skip_done    = ({1'b0, pos_cur} + 33'd1) >= {1'b0, start_cur};
    in_pad       = pad_cur != 2'd0;
    bpp3         = depth_cur == DEPTH_24;
    pix_end      = bpp3 ? (bip_cur == 2'd2) : (bip_cur == 2'd3);
    col_inc      = col_cur + 1'b1;
    row_inc      = row_cur + 1'b1;
    row_end      = col_inc == width_cur[CNT_W-1:0];
    last         = row_end && (row_inc == height_cur[CNT_W-1:0]);
    pixel_fire   = (phase_cur == PH_PIXELS) && !in_pad && pix_end;
    width_sat    = (|width_cur[31:14]) ? 14'h3FFF : width_cur[13:0];
    height_sat   = (|height_cur[31:14]) ? 14'h3FFF : height_cur[13:0];
    bpp_out      = (|depth_cur[15:6]) ? 3'd7 : depth_cur[5:3];
  end

  always_comb begin
    phase_next = phase_cur;
    unique case (phase_cur)
      PH_HEADER: begin
        if (hdr_check) begin
          if (hdr_status != ST_PIXEL) begin
            phase_next = PH_DONE;
          end else if (start_pixels) begin
            phase_next = PH_PIXELS;
          end else begin
            phase_next = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (skip_done) begin
          phase_next = PH_PIXELS;
        end
      end
      PH_PIXELS: begin
        if (pixel_fire && last) begin
          phase_next = PH_DONE;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase
  end

  always_comb begin
    pos_next    = (pos_cur == '1) ? pos_cur : pos_cur + 32'd1;
    sig_next    = sig_cur;
    width_next  = width_cur;
    height_next = height_cur;
    depth_next  = depth_cur;
    fmt_next    = fmt_cur;
    start_next  = start_cur;
    col_next    = col_cur;
    row_next    = row_cur;
    bip_next    = bip_cur;
    hold_next   = hold_cur;
    pad_next    = pad_cur;
    lane        = 2'd0;
    push        = 1'b0;
    result      = '0;
    result.image_width     = width_sat;
    result.image_height    = height_sat;
    result.bytes_per_pixel = bpp_out;
    result.status          = ST_PIXEL;

    if (phase_cur == PH_HEADER) begin
      if (pos6 <= POS_SIGNATURE_HI) begin
        sig_next = {sig_cur[7:0], b};
      end else if ((pos6 >= POS_OFFSET_LO) && (pos6 <= POS_OFFSET_LO + 6'd3)) begin
        lane = 2'(pos6 - POS_OFFSET_LO);
        start_next[{lane, 3'b000} +: 8] = b;
      end else if ((pos6 >= POS_WIDTH_LO) && (pos6 <= POS_WIDTH_LO + 6'd3)) begin
        lane = 2'(pos6 - POS_WIDTH_LO);
        width_next[{lane, 3'b000} +: 8] = b;
      end else if ((pos6 >= POS_HEIGHT_LO) && (pos6 <= POS_HEIGHT_LO + 6'd3)) begin
        lane = 2'(pos6 - POS_HEIGHT_LO);
        height_next[{lane, 3'b000} +: 8] = b;
      end else if ((pos6 >= POS_DEPTH_LO) && (pos6 <= POS_DEPTH_LO + 6'd1)) begin
        lane = 2'(pos6 - POS_DEPTH_LO);
        depth_next[{lane[0], 3'b000} +: 8] = b;
      end else if (((pos6 >= POS_COMP_LO) && (pos6 <= POS_COMP_LO + 6'd3)) ||
                   ((pos6 >= POS_PALETTE_LO) && (pos6 <= POS_PALETTE_LO + 6'd3))) begin
        fmt_next = fmt_cur | (b != 8'd0);
      end
      if (hdr_check && (hdr_status != ST_PIXEL)) begin
        push          = take;
        result.status = hdr_status;
      end
    end else if (phase_cur == PH_PIXELS) begin
      if (in_pad) begin
        pad_next = pad_cur - 2'd1;
      end else begin
        if (bip_cur != 2'd3) begin
          hold_next[{bip_cur, 3'b000} +: 8] = b;
        end
        if (!pix_end) begin
          bip_next = bip_cur + 2'd1;
        end else begin
          bip_next            = 2'd0;
          push                = take;
          result.red          = hold_next[23:16];
          result.green        = hold_next[15:8];
          result.blue         = hold_next[7:0];
          result.pixel_column = 13'(col_cur);
          result.pixel_row    = 13'(row_cur);
          result.last_pixel   = last;
          if (row_end) begin
            col_next = '0;
            row_next = row_inc;
            pad_next = bpp3 ? width_cur[1:0] : 2'd0;
          end else begin
            col_next = col_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      signature_word  <= '0;
      captured_width  <= '0;
      captured_height <= '0;
      bit_depth       <= '0;
      format_bad      <= 1'b0;
      pixel_start     <= '0;
      column_count    <= '0;
      row_count       <= '0;
      byte_in_pixel   <= '0;
      pixel_hold      <= '0;
      padding_left    <= '0;
      phase           <= PH_HEADER;
    end else if (take) begin
      byte_position   <= pos_next;
      signature_word  <= sig_next;
      captured_width  <= width_next;
      captured_height <= height_next;
      bit_depth       <= depth_next;
      format_bad      <= fmt_next;
      pixel_start     <= start_next;
      column_count    <= col_next;
      row_count       <= row_next;
      byte_in_pixel   <= bip_next;
      pixel_hold      <= hold_next;
      padding_left    <= pad_next;
      phase           <= phase_next;
    end
  end

  a_error_ends_parse: assert property (@(posedge clk) disable iff (rst)
    (push && (result.status != ST_PIXEL)) |=> (phase == PH_DONE))
    else $error("An error item did not leave the parse in the done phase.");

  a_last_ends_parse: assert property (@(posedge clk) disable iff (rst)
    (push && result.last_pixel) |=> (phase == PH_DONE))
    else $error("The last pixel item did not end the image.");

  a_push_needs_take: assert property (@(posedge clk) disable iff (rst)
    push |-> take)
    else $error("An item was built without an accepted byte.");

endmodule

// ===== rtl/core/bpse_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP extractor result queue
// Small first-in first-out queue that holds finished items until the
// consumer takes them, so that byte intake and result delivery stall apart.
// ----------------------------------------------------------------------------
module bpse_fifo
  import bpse_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  result_item_t wr_item,
  input  logic         pop,
  output logic         full,
  output logic         empty,
  output result_item_t rd_item
);

  localparam int unsigned PTR_W = $clog2(RESULT_FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(RESULT_FIFO_DEPTH + 1);

  result_item_t     slots [RESULT_FIFO_DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == CNT_W'(RESULT_FIFO_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = slots[head];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[tail] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == PTR_W'(RESULT_FIFO_DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (do_pop) begin
        head <= (head == PTR_W'(RESULT_FIFO_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(RESULT_FIFO_DEPTH))
    else $error("Queue fill count exceeds its depth.");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("An item was offered to a full queue.");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (count == $past(count) - 1'b1))
    else $error("A pop without a push did not lower the fill count.");

endmodule

// ===== rtl/core/bmp_pixel_stream_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP pixel stream extractor
// Parses an uncompressed 24 or 32 bit BMP file one byte at a time and
// delivers one RGB item per pixel, or one error item for a bad header.
//
//   Channel   Handshake            Payload
//   bytes     push / full          byte_item (data_byte, start_of_file)
//   results   empty / pop          result (colour, position, status, header)
//
// One byte is taken every cycle in which push is high and full is low; the
// front end updates its counters and header fields per byte. A result is
// queued as its byte is taken and shows once older results are popped.
// full rises only when all four queue slots hold results not yet popped.
// rst is synchronous and returns the parse to the header phase with an
// empty queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bmp_pixel_stream_extractor
  import bpse_pkg::*;
#(
  parameter int unsigned MAX_DIMENSION = MAX_DIMENSION_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         full,
  input  byte_item_t   byte_item,
  output logic         empty,
  input  logic         pop,
  output result_item_t result
);

  logic         take;
  logic         item_push;
  result_item_t item;

  assign take = push && !full;

  bpse_front #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .byte_item(byte_item),
    .push     (item_push),
    .result   (item)
  );

  bpse_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (item_push),
    .wr_item(item),
    .pop    (pop),
    .full   (full),
    .empty  (empty),
    .rd_item(result)
  );

endmodule

// ===== tb/bmp_pixel_stream_extractor_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP pixel stream extractor testbench
// Feeds the extractor a sequence of BMP files, one byte per item. A few
// hand-built files cover every header check and the layout corner cases.
// Random files follow: well-formed, damaged, cut short, or plain noise.
// A byte-level model of the parser predicts every result item. A monitor
// compares each popped item against the oldest prediction. Both sides idle
// at random, and the receiver sometimes holds off long enough to fill the
// queue.
// ----------------------------------------------------------------------------
module bmp_pixel_stream_extractor_tb;
  import bpse_pkg::*;

  typedef struct packed {
    logic       drain;
    logic [2:0] gap;
    byte_item_t item;
  } file_byte_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         push = 1'b0;
  logic         full;
  byte_item_t   byte_item = '0;
  logic         empty;
  logic         pop = 1'b0;
  result_item_t result;

  file_byte_t   file_bytes[$];
  result_item_t predicted_items[$];
  result_item_t oldest;
  file_byte_t   next_byte;

  int unsigned  bytes_built = 0;
  int unsigned  files_built = 0;
  int unsigned  bytes_offered = 0;
  int unsigned  bytes_taken = 0;
  int unsigned  results_seen = 0;
  int unsigned  results_handled = 0;
  int unsigned  pixels_predicted = 0;
  int unsigned  errors_predicted = 0;
  int unsigned  full_stall_cycles = 0;
  int unsigned  drains_taken = 0;
  int unsigned  mismatches = 0;
  int unsigned  gap_left = 0;
  int unsigned  pop_wait = 0;
  bit           gap_loaded = 1'b0;
  bit           quiet_sender = 1'b0;

  logic [31:0]  pos_count;
  logic [15:0]  sig_word;
  logic [31:0]  width_field;
  logic [31:0]  height_field;
  logic [15:0]  depth_field;
  logic [31:0]  comp_field;
  logic [31:0]  palette_field;
  logic [31:0]  data_offset;
  int unsigned  col_idx;
  int unsigned  row_idx;
  logic [1:0]   lane_idx;
  logic [23:0]  rgb_hold;
  logic [1:0]   pad_left;
  phase_t       parse_phase;

  bmp_pixel_stream_extractor i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .byte_item (byte_item),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= 200) begin
      $display("Mismatch in %s at result %0d: got %0d, expected %0d", what, results_seen,
               got, want);
    end
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      report_mismatch(name, got, want);
    end
  endtask

  function automatic void clear_parse();
    pos_count = '0;
    sig_word = '0;
    width_field = '0;
    height_field = '0;
    depth_field = '0;
    comp_field = '0;
    palette_field = '0;
    data_offset = '0;
    col_idx = 0;
    row_idx = 0;
    lane_idx = '0;
    rgb_hold = '0;
    pad_left = '0;
    parse_phase = PH_HEADER;
  endfunction

  function automatic status_t header_verdict();
    if (sig_word != BMP_SIGNATURE) return ST_BAD_SIGNATURE;
    if (comp_field != 0 || palette_field != 0) return ST_BAD_FORMAT;
    if (depth_field != DEPTH_24 && depth_field != DEPTH_32) return ST_BAD_GEOMETRY;
    if (width_field == 0 || width_field > MAX_DIMENSION_DEFAULT) return ST_BAD_GEOMETRY;
    if (height_field == 0 || height_field > MAX_DIMENSION_DEFAULT) return ST_BAD_GEOMETRY;
    return ST_PIXEL;
  endfunction

  function automatic void queue_result(input logic [23:0] rgb, input int unsigned col,
                                       input int unsigned row, input bit last,
                                       input status_t st);
    result_item_t r;
    int unsigned  bpp;
    bpp = depth_field >> 3;
    r.red = rgb[23:16];
    r.green = rgb[15:8];
    r.blue = rgb[7:0];
    r.pixel_column = col[12:0];
    r.pixel_row = row[12:0];
    r.last_pixel = last;
    r.status = st;
    r.image_width = (width_field > 16383) ? 14'd16383 : width_field[13:0];
    r.image_height = (height_field > 16383) ? 14'd16383 : height_field[13:0];
    r.bytes_per_pixel = (bpp > 7) ? 3'd7 : bpp[2:0];
    predicted_items.push_back(r);
    if (st == ST_PIXEL) begin
      pixels_predicted++;
    end else begin
      errors_predicted++;
    end
  endfunction

  function automatic void parse_bmp_byte(input byte_item_t it);
    logic [7:0]  b;
    int unsigned pos;
    int unsigned bpp;
    bit          last;
    status_t     st;
    b = it.data_byte;
    if (it.start_of_file) clear_parse();
    pos = pos_count;
    if (pos_count != 32'hFFFF_FFFF) pos_count++;
    case (parse_phase)
      PH_HEADER: begin
        if (pos <= 1) sig_word = {sig_word[7:0], b};
        else if (pos >= 10 && pos <= 13) data_offset[8*(pos-10) +: 8] = b;
        else if (pos >= 18 && pos <= 21) width_field[8*(pos-18) +: 8] = b;
        else if (pos >= 22 && pos <= 25) height_field[8*(pos-22) +: 8] = b;
        else if (pos >= 28 && pos <= 29) depth_field[8*(pos-28) +: 8] = b;
        else if (pos >= 30 && pos <= 33) comp_field[8*(pos-30) +: 8] = b;
        else if (pos >= 46 && pos <= 49) palette_field[8*(pos-46) +: 8] = b;
        if (pos == 32'(HEADER_LAST)) begin
          st = header_verdict();
          if (st != ST_PIXEL) begin
            queue_result(24'd0, 0, 0, 1'b0, st);
            parse_phase = PH_DONE;
          end else if (data_offset <= 32'(HEADER_LAST) + 32'd1) begin
            parse_phase = PH_PIXELS;
          end else begin
            parse_phase = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if ({32'd0, pos} + 64'd1 >= {32'd0, data_offset}) parse_phase = PH_PIXELS;
      end
      PH_PIXELS: begin
        bpp = depth_field >> 3;
        if (pad_left != 0) begin
          pad_left--;
          return;
        end
        if (lane_idx < 3) rgb_hold[8*lane_idx +: 8] = b;
        if (32'(lane_idx) + 32'd1 < bpp) begin
          lane_idx++;
          return;
        end
        lane_idx = '0;
        last = (col_idx + 1 == width_field) && (row_idx + 1 == height_field);
        queue_result(rgb_hold, col_idx, row_idx, last, ST_PIXEL);
        col_idx++;
        if (col_idx >= width_field) begin
          col_idx = 0;
          row_idx++;
          pad_left = 2'((4 - ((width_field * bpp) & 3)) & 3);
        end
        if (last) parse_phase = PH_DONE;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void queue_byte(input logic [7:0] b, input bit sof, input bit drain);
    file_byte_t e;
    e.item.data_byte = b;
    e.item.start_of_file = sof;
    e.drain = drain;
    e.gap = quiet_sender ? 3'd0 : 3'($urandom_range(0, 4));
    file_bytes.push_back(e);
    bytes_built++;
  endfunction

  task automatic add_file(input logic [15:0] sig, input logic [31:0] offset,
                          input logic [31:0] w, input logic [31:0] h,
                          input logic [15:0] depth, input logic [31:0] comp,
                          input logic [31:0] pal, input bit sof,
                          input int unsigned cut, input bit drain);
    logic [7:0]  hdr [0:53];
    int unsigned skip_len;
    int unsigned row_len;
    int unsigned pad;
    int unsigned body_len;
    int unsigned total;
    int unsigned n;
    for (int i = 0; i < 54; i++) hdr[i] = 8'($urandom);
    hdr[0] = sig[15:8];
    hdr[1] = sig[7:0];
    for (int k = 0; k < 4; k++) begin
      hdr[10+k] = offset[8*k +: 8];
      hdr[18+k] = w[8*k +: 8];
      hdr[22+k] = h[8*k +: 8];
      hdr[30+k] = comp[8*k +: 8];
      hdr[46+k] = pal[8*k +: 8];
    end
    hdr[28] = depth[7:0];
    hdr[29] = depth[15:8];
    skip_len = (offset > 54) ? ((offset - 54 > 40) ? 40 : offset - 54) : 0;
    if ((depth == DEPTH_24 || depth == DEPTH_32) && w >= 1 && w <= 64 && h >= 1 &&
        h <= 64) begin
      row_len = w * (depth >> 3);
      pad = (4 - (row_len % 4)) % 4;
      body_len = h * (row_len + pad);
    end else begin
      body_len = 16;
    end
    total = 54 + skip_len + body_len;
    n = (cut < total) ? cut : total;
    for (int i = 0; i < n; i++) begin
      queue_byte((i < 54) ? hdr[i] : 8'($urandom), sof && i == 0, drain && i == 0);
    end
    files_built++;
  endtask

  // Sender: offers queued bytes, idling before each one as drawn and holding a drain byte until no prediction is left.
  always @(negedge clk) begin
    if (!rst && !(push && bytes_taken != bytes_offered)) begin
      if (file_bytes.size() == 0) begin
        push <= 1'b0;
      end else begin
        if (!gap_loaded) begin
          gap_left = file_bytes[0].gap;
          gap_loaded = 1'b1;
        end
        if (gap_left > 0) begin
          push <= 1'b0;
          gap_left--;
        end else if (file_bytes[0].drain && predicted_items.size() != 0) begin
          push <= 1'b0;
        end else begin
          next_byte = file_bytes.pop_front();
          byte_item <= next_byte.item;
          push <= 1'b1;
          bytes_offered++;
          gap_loaded = 1'b0;
          if (next_byte.drain) drains_taken++;
        end
      end
    end
  end

  // Receiver: pops results, stalling between them and now and then for long.
  always @(negedge clk) begin
    if (!rst) begin
      if (results_seen != results_handled) begin
        results_handled = results_seen;
        if (results_seen % 40 == 20) begin
          pop_wait = 150;
        end else if ((results_seen / 25) % 3 == 0) begin
          pop_wait = 0;
        end else begin
          pop_wait = $urandom_range(0, 4);
        end
      end
      if (pop_wait > 0) begin
        pop <= 1'b0;
        pop_wait--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Monitor: checks popped results, then predicts from the accepted byte.
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        results_seen++;
        if (predicted_items.size() == 0) begin
          report_mismatch("unpredicted result item", result.status, 0);
        end else begin
          oldest = predicted_items.pop_front();
          check_field("red", result.red, oldest.red);
          check_field("green", result.green, oldest.green);
          check_field("blue", result.blue, oldest.blue);
          check_field("pixel_column", result.pixel_column, oldest.pixel_column);
          check_field("pixel_row", result.pixel_row, oldest.pixel_row);
          check_field("last_pixel", result.last_pixel, oldest.last_pixel);
          check_field("status", result.status, oldest.status);
          check_field("image_width", result.image_width, oldest.image_width);
          check_field("image_height", result.image_height, oldest.image_height);
          check_field("bytes_per_pixel", result.bytes_per_pixel, oldest.bytes_per_pixel);
        end
      end
      if (push && full) full_stall_cycles++;
      if (push && !full) begin
        bytes_taken++;
        parse_bmp_byte(byte_item);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int unsigned kind;
    int unsigned rw;
    int unsigned rh;
    int unsigned roff;
    int unsigned rcut;
    int unsigned rcomp;
    int unsigned rpal;
    logic [15:0] rdepth;
    logic [15:0] rsig;
    bit          drain;
    clear_parse();

    // The first file after reset carries no start marker.
    add_file(BMP_SIGNATURE, 54, 1, 2, DEPTH_24, 0, 0, 1'b0, 1000, 1'b0);
    quiet_sender = 1'b1;
    add_file(BMP_SIGNATURE, 62, 3, 2, DEPTH_32, 0, 0, 1'b1, 1000, 1'b0);
    quiet_sender = 1'b0;
    add_file(BMP_SIGNATURE, 14, 2, 1, DEPTH_24, 0, 0, 1'b1, 1000, 1'b0);
    add_file(16'h4D42, 54, 2, 2, DEPTH_24, 0, 0, 1'b1, 1000, 1'b1);
    add_file(BMP_SIGNATURE, 54, 2, 2, DEPTH_24, 1, 0, 1'b1, 1000, 1'b0);
    add_file(BMP_SIGNATURE, 54, 2, 2, DEPTH_24, 0, 32'h8000_0000, 1'b1, 1000, 1'b0);
    add_file(BMP_SIGNATURE, 54, 2, 2, 16'd8, 0, 0, 1'b1, 1000, 1'b0);
    add_file(BMP_SIGNATURE, 54, 2, 2, 16'hFFFF, 0, 0, 1'b1, 1000, 1'b0);
    add_file(BMP_SIGNATURE, 54, 0, 2, DEPTH_24, 0, 0, 1'b1, 1000, 1'b0);
    add_file(BMP_SIGNATURE, 54, 2, 0, DEPTH_32, 0, 0, 1'b1, 1000, 1'b0);
    add_file(BMP_SIGNATURE, 54, 8193, 2, DEPTH_24, 0, 0, 1'b1, 1000, 1'b0);
    add_file(BMP_SIGNATURE, 54, 2, 32'hFFFF_FFFF, DEPTH_24, 0, 0, 1'b1, 1000, 1'b0);
    add_file(BMP_SIGNATURE, 54, 32'hFFFF_FFFF, 32'h0001_0000, DEPTH_32, 0, 0, 1'b1, 1000,
             1'b0);
    // Largest legal image, cut short inside a pixel and restarted.
    add_file(BMP_SIGNATURE, 54, 8192, 8192, DEPTH_32, 0, 0, 1'b1, 67, 1'b0);
    add_file(BMP_SIGNATURE, 32'hFFFF_FFFF, 2, 2, DEPTH_24, 0, 0, 1'b1, 1000, 1'b0);
    add_file(BMP_SIGNATURE, 54, 3, 3, DEPTH_24, 0, 0, 1'b1, 30, 1'b0);
    add_file(BMP_SIGNATURE, 54, 3, 1, DEPTH_24, 0, 0, 1'b1, 1000, 1'b0);
    for (int i = 0; i < 6; i++) queue_byte(8'($urandom), 1'b0, 1'b0);

    while (bytes_built < 1350) begin
      kind = $urandom_range(0, 9);
      quiet_sender = ($urandom_range(0, 3) == 0);
      drain = (files_built % 5 == 4);
      rw = $urandom_range(1, 6);
      rh = $urandom_range(1, 3);
      rdepth = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
      case ($urandom_range(0, 3))
        0, 1: roff = 54;
        2: roff = 54 + $urandom_range(1, 8);
        default: roff = $urandom_range(0, 53);
      endcase
      rsig = BMP_SIGNATURE;
      rcomp = 0;
      rpal = 0;
      rcut = 32'hFFFF_FFFF;
      if (kind == 7) begin
        case ($urandom_range(0, 4))
          0: begin
            rsig = 16'($urandom);
            if (rsig == BMP_SIGNATURE) rsig = ~rsig;
          end
          1: rcomp = $urandom_range(32'hFFFF_FFFF, 1);
          2: rpal = $urandom_range(32'hFFFF_FFFF, 1);
          3: begin
            rdepth = 16'($urandom);
            if (rdepth == DEPTH_24 || rdepth == DEPTH_32) rdepth = 16'd8;
          end
          default: begin
            if ($urandom_range(0, 1)) begin
              rw = $urandom_range(0, 1) ? 0 : $urandom_range(32'hFFFF_FFFF, 8193);
            end else begin
              rh = $urandom_range(0, 1) ? 0 : $urandom_range(32'hFFFF_FFFF, 8193);
            end
          end
        endcase
      end else if (kind == 8) begin
        rcut = $urandom_range(1, 120);
      end
      if (kind == 9) begin
        repeat ($urandom_range(1, 20)) begin
          queue_byte(8'($urandom), $urandom_range(0, 7) == 0, 1'b0);
        end
      end else begin
        add_file(rsig, roff, rw, rh, rdepth, rcomp, rpal, 1'b1, rcut, drain);
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (file_bytes.size() != 0 || bytes_taken != bytes_offered) @(posedge clk);
    while (predicted_items.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d files in %0d bytes: %0d pixel items and %0d header errors.",
             files_built, bytes_taken, pixels_predicted, errors_predicted);
    $display("Input held off by full on %0d cycles; %0d drain pauses.", full_stall_cycles,
             drains_taken);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
